FILE: rtl/core/lbr_pkg.sv
// shared types and constants for the rest-to-lab boost pipeline
// no dependencies; used by lbr_dot, lbr_div and lorentz_boost_rest_to_lab
`timescale 1ns / 1ps
`default_nettype none

package lbr_pkg;

   localparam int unsigned WORD_W = 32;
   // magnitude of the four-term dot product, at most 2^64
   localparam int unsigned DOT_NW = 65;
   // magnitude of the parent mass
   localparam int unsigned PM_DW  = 32;
   // magnitude of lab energy plus child energy
   localparam int unsigned NUM_W  = 66;
   localparam int unsigned PROD_W = NUM_W + WORD_W;
   // magnitude of parent energy plus parent mass
   localparam int unsigned DEN_DW = 33;
   // quotient bits kept for the momentum terms, larger values saturate
   localparam int unsigned MOM_QW = 33;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_ZDIV = 2'd1;
   localparam logic [1:0] STAT_SAT  = 2'd2;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [31:0] energy;
      logic [31:0] mass;
   } child_type;

   typedef struct packed {
      child_type   ch;
      logic [2:0][31:0] pp;
      logic [31:0] pe;
      logic [31:0] pm;
   } req_type;

   typedef struct packed {
      child_type   ch;
      logic        bypass;
      logic        zdiv;
      logic [2:0][31:0] pp;
      logic [32:0] den;
   } side_type;

endpackage

`default_nettype wire

FILE: rtl/core/lbr_dot.sv
// four-stage front end: products, adder tree, magnitude of the dot product
// depends on lbr_pkg
`timescale 1ns / 1ps
`default_nettype none

module lbr_dot (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  lbr_pkg::req_type            in_req,
   output logic                        out_valid,
   output logic [lbr_pkg::DOT_NW-1:0]  out_mag,
   output logic                        out_neg,
   output logic [lbr_pkg::PM_DW-1:0]   out_pm_mag,
   output lbr_pkg::side_type           out_side
);

   logic signed [63:0] prod_in [4];
   logic signed [63:0] prod1_ff [4];
   logic [32:0]        den_in;
   logic               rest_in;
   logic               zero_in;
   lbr_pkg::side_type  side_in;
   lbr_pkg::side_type  side1_ff, side2_ff, side3_ff, side4_ff;
   logic [31:0]        pm1_ff, pm2_ff, pm3_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [64:0]        sa2_ff, sb2_ff;
   logic [65:0]        dot3_ff;
   logic [65:0]        dabs;
   logic [31:0]        pabs;
   logic [64:0]        mag4_ff;
   logic               neg4_ff;
   logic [31:0]        pmag4_ff;

   assign prod_in[0] = $signed(in_req.ch.px) * $signed(in_req.pp[0]);
   assign prod_in[1] = $signed(in_req.ch.py) * $signed(in_req.pp[1]);
   assign prod_in[2] = $signed(in_req.ch.pz) * $signed(in_req.pp[2]);
   assign prod_in[3] = $signed(in_req.ch.energy) * $signed(in_req.pe);

   assign den_in  = {in_req.pe[31], in_req.pe} + {in_req.pm[31], in_req.pm};
   assign rest_in = (in_req.pe == in_req.pm);
   assign zero_in = (in_req.pm == 32'd0) || (den_in == 33'd0);

   always_comb begin
      side_in        = '0;
      side_in.ch     = in_req.ch;
      side_in.pp     = in_req.pp;
      side_in.den    = den_in;
      side_in.bypass = rest_in | zero_in;
      side_in.zdiv   = ~rest_in & zero_in;
   end

   assign dabs = dot3_ff[65] ? (~dot3_ff + 66'd1) : dot3_ff;
   assign pabs = pm3_ff[31] ? (~pm3_ff + 32'd1) : pm3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            prod1_ff[i] <= prod_in[i];
         end
         side1_ff <= side_in;
         pm1_ff   <= in_req.pm;
         sa2_ff   <= {prod1_ff[0][63], prod1_ff[0]} + {prod1_ff[1][63], prod1_ff[1]};
         sb2_ff   <= {prod1_ff[2][63], prod1_ff[2]} + {prod1_ff[3][63], prod1_ff[3]};
         side2_ff <= side1_ff;
         pm2_ff   <= pm1_ff;
         dot3_ff  <= {sa2_ff[64], sa2_ff} + {sb2_ff[64], sb2_ff};
         side3_ff <= side2_ff;
         pm3_ff   <= pm2_ff;
         mag4_ff  <= dabs[64:0];
         neg4_ff  <= dot3_ff[65] ^ pm3_ff[31];
         pmag4_ff <= pabs;
         side4_ff <= side3_ff;
      end
   end

   assign out_valid  = v4_ff;
   assign out_mag    = mag4_ff;
   assign out_neg    = neg4_ff;
   assign out_pm_mag = pmag4_ff;
   assign out_side   = side4_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lbr_div.sv
// pipelined restoring divider on magnitudes, one quotient bit per stage
// depends on lbr_pkg for default widths; the high part of the numerator must be below the divisor
`timescale 1ns / 1ps
`default_nettype none

module lbr_div #(
   parameter int unsigned NW = lbr_pkg::DOT_NW,
   parameter int unsigned DW = lbr_pkg::PM_DW,
   parameter int unsigned QW = lbr_pkg::DOT_NW,
   parameter int unsigned SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo,
   output logic [SW-1:0] out_side
);

   logic [DW-1:0] rem0;
   logic [DW-1:0] rem_ff  [QW+1];
   logic [QW-1:0] low_ff  [QW+1];
   logic [QW-1:0] quo_ff  [QW+1];
   logic [DW-1:0] den_ff  [QW+1];
   logic [SW-1:0] side_ff [QW+1];
   logic          vld_ff  [QW+1];

   generate
      if (NW > QW) begin : g_hi
         assign rem0 = DW'(in_num[NW-1:QW]);
      end else begin : g_nohi
         assign rem0 = '0;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int k = 0; k < QW; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem0;
         low_ff[0]  <= in_num[QW-1:0];
         quo_ff[0]  <= '0;
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
      end
   end

   genvar k;
   generate
      for (k = 0; k < QW; k++) begin : g_step
         logic [DW:0]   trial;
         logic          ge;
         logic [DW-1:0] rem_in;

         assign trial  = {rem_ff[k], low_ff[k][QW-1]};
         assign ge     = trial >= {1'b0, den_ff[k]};
         assign rem_in = ge ? DW'(trial - {1'b0, den_ff[k]}) : trial[DW-1:0];

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k+1]  <= rem_in;
               low_ff[k+1]  <= low_ff[k] << 1;
               quo_ff[k+1]  <= {quo_ff[k][QW-2:0], ge};
               den_ff[k+1]  <= den_ff[k];
               side_ff[k+1] <= side_ff[k];
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_side  = side_ff[QW];

   // partial remainder always stays below a nonzero divisor
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QW] && den_ff[QW] != '0) |-> (rem_ff[QW] < den_ff[QW]))
      else $error("lbr_div: remainder not below divisor");

endmodule

`default_nettype wire

FILE: rtl/core/lorentz_boost_rest_to_lab.sv
// top level of the rest-to-lab boost: front end, energy divider, scaling and momentum dividers
// depends on lbr_pkg, lbr_dot and lbr_div
//
// Usage: one request carries a parent four-momentum with its mass (lab frame) and a child
// four-momentum with its mass (parent rest frame); one response carries the child in the lab
// frame plus a status code (ok, zero divisor, saturated).
// Both channels are valid/ready. A request is taken whenever req_ready is high, which is the
// case unless a response sits in the output register and rsp_ready is low.
// Throughput: one request per cycle, sustained while the receiver takes responses.
// The pipeline is built from the 65-stage energy divider (one quotient bit per stage) and the
// 33-stage momentum dividers, plus the stages of products, adder tree, sign handling and
// saturation.
// Reset empties the pipeline; nothing is in flight afterward and rsp_valid is low.
// When the receiver stalls, the whole pipeline holds in place; no request is lost or repeated,
// and req_ready drops until the held response is taken.
// A parent at rest (energy equal to mass) or a zero divisor passes the child through.
`timescale 1ns / 1ps
`default_nettype none

module lorentz_boost_rest_to_lab (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_parent_px,
   input  logic [31:0] req_parent_py,
   input  logic [31:0] req_parent_pz,
   input  logic [31:0] req_parent_energy,
   input  logic [31:0] req_parent_mass,
   input  logic [31:0] req_child_px,
   input  logic [31:0] req_child_py,
   input  logic [31:0] req_child_pz,
   input  logic [31:0] req_child_energy,
   input  logic [31:0] req_child_mass,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_lab_px,
   output logic [31:0] rsp_lab_py,
   output logic [31:0] rsp_lab_pz,
   output logic [31:0] rsp_lab_energy,
   output logic [31:0] rsp_lab_mass,
   output logic [1:0]  rsp_status
);

   localparam int unsigned SIDE_W = $bits(lbr_pkg::side_type);
   localparam int unsigned NW     = lbr_pkg::NUM_W;
   localparam int unsigned PW     = lbr_pkg::PROD_W;
   localparam int unsigned DDW    = lbr_pkg::DEN_DW;
   localparam int unsigned MQW    = lbr_pkg::MOM_QW;
   localparam int unsigned EQW    = lbr_pkg::DOT_NW;
   localparam int unsigned XSW    = 32 + 1 + 2 + SIDE_W;

   logic adv;

   lbr_pkg::req_type req;

   logic                       dot_v;
   logic [lbr_pkg::DOT_NW-1:0] dot_mag;
   logic                       dot_neg;
   logic [lbr_pkg::PM_DW-1:0]  dot_pm_mag;
   lbr_pkg::side_type          dot_side;

   logic            d1_v;
   logic [EQW-1:0]  d1_q;
   logic [SIDE_W:0] d1_side;

   // energy and scaling stages
   logic [65:0]        elab5_ff;
   lbr_pkg::side_type  side5_ff, side6_ff, side7_ff, side8_ff, side9_ff, side10_ff;
   logic               v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff, out_v_ff;
   logic [66:0]        num6_ff;
   logic [31:0]        e6_ff, e7_ff, e8_ff, e9_ff, e10_ff;
   logic               esat6_ff, esat7_ff, esat8_ff, esat9_ff, esat10_ff;
   logic [66:0]        nabs;
   logic [32:0]        dabs;
   logic [NW-1:0]      nmag7_ff;
   logic [DDW-1:0]     dmag7_ff, dmag8_ff, dmag9_ff, dmag10_ff;
   logic [31:0]        ppm7_ff [3];
   logic [2:0]         sgn7_ff, sgn8_ff, sgn9_ff, sgn10_ff;
   logic [63:0]        lo8_ff  [3];
   logic [63:0]        mid8_ff [3];
   logic [33:0]        hi8_ff  [3];
   logic [PW-1:0]      prod9_ff [3];
   logic [PW-1:0]      n10_ff [3];
   logic [2:0]         ovf10_ff;

   logic [MQW-1:0]     d2_q [3];
   logic [2:0]         d2_v;
   logic [XSW-1:0]     dx_side;
   logic [1:0]         dy_side, dz_side;

   // final stages
   logic [33:0]        t11_ff [3];
   logic [2:0]         ovf11_ff, sgn11_ff;
   logic [31:0]        e11_ff;
   logic               esat11_ff;
   lbr_pkg::side_type  side11_ff;

   logic [31:0]        lab_in [3];
   logic [2:0]         sat_in;
   logic [31:0]        cp [3];
   logic [34:0]        sum;
   logic [31:0]        px_ff, py_ff, pz_ff, en_ff, mass_ff;
   logic [1:0]         status_ff;
   logic               out_bp_ff;
   logic [31:0]        px_in, py_in, pz_in, en_in;
   logic [1:0]         status_in;

   assign adv       = ~out_v_ff | rsp_ready;
   assign req_ready = adv;

   always_comb begin
      req           = '0;
      req.ch.px     = req_child_px;
      req.ch.py     = req_child_py;
      req.ch.pz     = req_child_pz;
      req.ch.energy = req_child_energy;
      req.ch.mass   = req_child_mass;
      req.pp[0]     = req_parent_px;
      req.pp[1]     = req_parent_py;
      req.pp[2]     = req_parent_pz;
      req.pe        = req_parent_energy;
      req.pm        = req_parent_mass;
   end

   lbr_dot u_dot (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (req_valid),
      .in_req     (req),
      .out_valid  (dot_v),
      .out_mag    (dot_mag),
      .out_neg    (dot_neg),
      .out_pm_mag (dot_pm_mag),
      .out_side   (dot_side)
   );

   lbr_div #(
      .NW (lbr_pkg::DOT_NW),
      .DW (lbr_pkg::PM_DW),
      .QW (EQW),
      .SW (SIDE_W + 1)
   ) u_div_energy (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dot_v),
      .in_num    (dot_mag),
      .in_den    (dot_pm_mag),
      .in_side   ({dot_neg, dot_side}),
      .out_valid (d1_v),
      .out_quo   (d1_q),
      .out_side  (d1_side)
   );

   assign nabs = num6_ff[66] ? (~num6_ff + 67'd1) : num6_ff;
   assign dabs = side6_ff.den[32] ? (~side6_ff.den + 33'd1) : side6_ff.den;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
      end else if (adv) begin
         v5_ff  <= d1_v;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // signed lab energy from the quotient magnitude
         elab5_ff <= d1_side[SIDE_W] ? (~{1'b0, d1_q} + 66'd1) : {1'b0, d1_q};
         side5_ff <= lbr_pkg::side_type'(d1_side[SIDE_W-1:0]);

         num6_ff  <= {elab5_ff[65], elab5_ff} + {{35{side5_ff.ch.energy[31]}}, side5_ff.ch.energy};
         if ((&elab5_ff[65:31]) || !(|elab5_ff[65:31])) begin
            e6_ff    <= elab5_ff[31:0];
            esat6_ff <= 1'b0;
         end else begin
            e6_ff    <= elab5_ff[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            esat6_ff <= 1'b1;
         end
         side6_ff <= side5_ff;

         nmag7_ff <= nabs[NW-1:0];
         dmag7_ff <= dabs;
         for (int i = 0; i < 3; i++) begin
            ppm7_ff[i] <= side6_ff.pp[i][31] ? (~side6_ff.pp[i] + 32'd1) : side6_ff.pp[i];
            sgn7_ff[i] <= num6_ff[66] ^ side6_ff.pp[i][31] ^ side6_ff.den[32];
         end
         e7_ff    <= e6_ff;
         esat7_ff <= esat6_ff;
         side7_ff <= side6_ff;

         // 66 x 32 product split into three partial products
         for (int i = 0; i < 3; i++) begin
            lo8_ff[i]  <= nmag7_ff[31:0] * ppm7_ff[i];
            mid8_ff[i] <= nmag7_ff[63:32] * ppm7_ff[i];
            hi8_ff[i]  <= nmag7_ff[65:64] * ppm7_ff[i];
         end
         dmag8_ff <= dmag7_ff;
         sgn8_ff  <= sgn7_ff;
         e8_ff    <= e7_ff;
         esat8_ff <= esat7_ff;
         side8_ff <= side7_ff;

         for (int i = 0; i < 3; i++) begin
            prod9_ff[i] <= {34'd0, lo8_ff[i]} + {2'd0, mid8_ff[i], 32'd0} + {hi8_ff[i], 64'd0};
         end
         dmag9_ff <= dmag8_ff;
         sgn9_ff  <= sgn8_ff;
         e9_ff    <= e8_ff;
         esat9_ff <= esat8_ff;
         side9_ff <= side8_ff;

         // quotient at or beyond 2^33 always saturates, so only its low bits are divided
         for (int i = 0; i < 3; i++) begin
            ovf10_ff[i] <= prod9_ff[i][PW-1:MQW] >= {32'd0, dmag9_ff};
            n10_ff[i]   <= (prod9_ff[i][PW-1:MQW] >= {32'd0, dmag9_ff})
                           ? {{(PW-MQW){1'b0}}, prod9_ff[i][MQW-1:0]} : prod9_ff[i];
         end
         dmag10_ff <= dmag9_ff;
         sgn10_ff  <= sgn9_ff;
         e10_ff    <= e9_ff;
         esat10_ff <= esat9_ff;
         side10_ff <= side9_ff;
      end
   end

   lbr_div #(
      .NW (PW),
      .DW (DDW),
      .QW (MQW),
      .SW (XSW)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v10_ff),
      .in_num    (n10_ff[0]),
      .in_den    (dmag10_ff),
      .in_side   ({e10_ff, esat10_ff, ovf10_ff[0], sgn10_ff[0], side10_ff}),
      .out_valid (d2_v[0]),
      .out_quo   (d2_q[0]),
      .out_side  (dx_side)
   );

   lbr_div #(
      .NW (PW),
      .DW (DDW),
      .QW (MQW),
      .SW (2)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v10_ff),
      .in_num    (n10_ff[1]),
      .in_den    (dmag10_ff),
      .in_side   ({ovf10_ff[1], sgn10_ff[1]}),
      .out_valid (d2_v[1]),
      .out_quo   (d2_q[1]),
      .out_side  (dy_side)
   );

   lbr_div #(
      .NW (PW),
      .DW (DDW),
      .QW (MQW),
      .SW (2)
   ) u_div_z (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v10_ff),
      .in_num    (n10_ff[2]),
      .in_den    (dmag10_ff),
      .in_side   ({ovf10_ff[2], sgn10_ff[2]}),
      .out_valid (d2_v[2]),
      .out_quo   (d2_q[2]),
      .out_side  (dz_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else if (adv) begin
         v11_ff <= d2_v[0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t11_ff[0]   <= dx_side[SIDE_W] ? (~{1'b0, d2_q[0]} + 34'd1) : {1'b0, d2_q[0]};
         t11_ff[1]   <= dy_side[0] ? (~{1'b0, d2_q[1]} + 34'd1) : {1'b0, d2_q[1]};
         t11_ff[2]   <= dz_side[0] ? (~{1'b0, d2_q[2]} + 34'd1) : {1'b0, d2_q[2]};
         ovf11_ff    <= {dz_side[1], dy_side[1], dx_side[SIDE_W+1]};
         sgn11_ff    <= {dz_side[0], dy_side[0], dx_side[SIDE_W]};
         e11_ff      <= dx_side[XSW-1:XSW-32];
         esat11_ff   <= dx_side[SIDE_W+2];
         side11_ff   <= lbr_pkg::side_type'(dx_side[SIDE_W-1:0]);
      end
   end

   always_comb begin
      cp[0] = side11_ff.ch.px;
      cp[1] = side11_ff.ch.py;
      cp[2] = side11_ff.ch.pz;
      sum   = '0;
      for (int i = 0; i < 3; i++) begin
         sum = {t11_ff[i][33], t11_ff[i]} + {{3{cp[i][31]}}, cp[i]};
         if (ovf11_ff[i]) begin
            lab_in[i] = sgn11_ff[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat_in[i] = 1'b1;
         end else if ((&sum[34:31]) || !(|sum[34:31])) begin
            lab_in[i] = sum[31:0];
            sat_in[i] = 1'b0;
         end else begin
            lab_in[i] = sum[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            sat_in[i] = 1'b1;
         end
      end
      if (side11_ff.bypass) begin
         px_in     = side11_ff.ch.px;
         py_in     = side11_ff.ch.py;
         pz_in     = side11_ff.ch.pz;
         en_in     = side11_ff.ch.energy;
         status_in = side11_ff.zdiv ? lbr_pkg::STAT_ZDIV : lbr_pkg::STAT_OK;
      end else begin
         px_in     = lab_in[0];
         py_in     = lab_in[1];
         pz_in     = lab_in[2];
         en_in     = e11_ff;
         status_in = ((|sat_in) || esat11_ff) ? lbr_pkg::STAT_SAT : lbr_pkg::STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v11_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff     <= px_in;
         py_ff     <= py_in;
         pz_ff     <= pz_in;
         en_ff     <= en_in;
         mass_ff   <= side11_ff.ch.mass;
         status_ff <= status_in;
         out_bp_ff <= side11_ff.bypass;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_lab_px     = px_ff;
   assign rsp_lab_py     = py_ff;
   assign rsp_lab_pz     = pz_ff;
   assign rsp_lab_energy = en_ff;
   assign rsp_lab_mass   = mass_ff;
   assign rsp_status     = status_ff;

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("boost: response valid right after reset");

   a_bypass_not_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_bp_ff) |-> (rsp_status != lbr_pkg::STAT_SAT))
      else $error("boost: pass-through request flagged as saturated");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      (!adv && v11_ff) |=> (v11_ff && $stable(t11_ff[0])))
      else $error("boost: pipeline moved during a stall");

   // the three momentum lanes carry the same request
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      (d2_v[1] == d2_v[0]) && (d2_v[2] == d2_v[0]))
      else $error("boost: momentum dividers out of step");

endmodule

`default_nettype wire
